// ===== rtl/sfur_pkg.sv =====
// Package with the types, codes and constants of the serial firmware update receiver.
package sfur_pkg;

  localparam int unsigned PAGE_BYTES_DEF  = 256;
  localparam int unsigned FRAME_BYTES_DEF = 16;

  localparam int unsigned OFF_W = 22;
  localparam int unsigned EO_W  = 23;
  localparam int unsigned LEN_W = 22;

  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] ERASED     = 8'hFF;

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(2048 * 1024);

  localparam logic CFG_LIMIT   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BANNER,
    ST_EVAL,
    ST_REFUSE,
    ST_ERASE,
    ST_ACK,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/serial_firmware_update_receiver_top.sv =====
// Serial firmware update receiver: framing, page buffer memory, flush and acknowledge sequencer.
//
// The input channel carries one action per transfer: a start request (action 0) or one
// received serial byte (action 1). The output channel carries one result per transfer:
// a byte to transmit, a bank erase request, a 64-bit flash word write or the done marker,
// with last set on the final result that one input causes.
// A byte that does not complete a frame causes no result.
// A byte that completes a frame holds the input stalled while the sequencer works:
// evaluation, a read and a write per payload byte copied from the frame memory into the
// page memory, a read and a write per flash word when the page is flushed (PAGE_BYTES/8
// words) and then each emitted byte.
// Results pass through one output register, so the next input is taken while the last
// result of the previous one still waits; a stalled receiver halts the sequencer in the
// states that emit a result. Reset clears the session, the page buffer reads as erased
// (0xFF) at once and the configuration registers return to their defaults. The user must
// write the configuration only while the block is idle; the block does not enforce this.
module serial_firmware_update_receiver_top
  import sfur_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        tx_byte_o,
  output logic [OFF_W-1:0]  flash_offset_o,
  output logic [63:0]       flash_data_o,
  output logic              last_o
);

  localparam int unsigned ROWS  = PAGE_BYTES / 8;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned PIW   = $clog2(PAGE_BYTES);
  localparam int unsigned FCW   = $clog2(FRAME_BYTES + 1);
  localparam int unsigned FAW   = $clog2(FRAME_BYTES);
  localparam int unsigned CW0   = (RW > FCW) ? RW : FCW;
  localparam int unsigned CW    = (CW0 > 3) ? CW0 : 3;

  state_e state_q, state_d;

  logic [LEN_W-1:0] limit_q;
  logic [31:0]      version_q;

  logic [FCW-1:0]   fc_q;
  logic [FCW-1:0]   size_q;
  logic [7:0]       hdr0_q;
  logic [31:0]      len_q;
  logic [31:0]      seq_q;
  logic [15:0]      rxsum_q;
  logic [15:0]      sum_q;
  logic [7:0]       lo_q;
  logic [LEN_W-1:0] total_q;
  logic [EO_W-1:0]  eo_q;
  logic [PIW-1:0]   idx_q;
  logic [OFF_W-1:0] base_q;
  logic             finished_q;
  logic             ack_data_q;
  logic [CW-1:0]    cnt_q;

  logic [7:0]       frame_mem [FRAME_BYTES];
  logic [7:0]       frame_rd_q;
  logic [63:0]      page_mem [ROWS];
  logic [63:0]      page_rd_q;
  logic [7:0]       vld_rd_q;
  logic [PAGE_BYTES-1:0] valid_q;

  logic             in_acc;
  logic             byte_acc;
  logic             emit_ok;
  logic [FCW-1:0]   fc_next;
  logic             frame_end;
  logic [FCW-1:0]   psize;
  logic [PIW:0]     wr_pos;
  logic [PIW:0]     fill;
  logic [EO_W-1:0]  eo_new;
  logic             flush_need;
  logic             copy_last;
  logic             row_last;
  logic             refuse;
  logic [23:0]      reach;

  logic             emit;
  kind_e            kind;
  logic [7:0]       tx;
  logic [OFF_W-1:0] off;
  logic [63:0]      data;
  logic             last;

  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [7:0]       tx_q;
  logic [OFF_W-1:0] off_q;
  logic [63:0]      data_q;
  logic             last_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_acc   = in_acc && (action_i == ACT_BYTE) && !finished_q;
  assign emit_ok    = !out_valid_q || !out_stall_i;

  assign fc_next = fc_q + FCW'(1);
  assign reach   = 24'(fc_next) - 24'd8 + 24'(eo_q);

  always_comb begin
    frame_end = 1'b0;
    if (fc_next > FCW'(2)) begin
      if (total_q == '0) begin
        frame_end = (fc_next == FCW'(6));
      end else if (fc_next > FCW'(8) && 24'(total_q) <= reach) begin
        frame_end = 1'b1;
      end
      if (fc_next >= FCW'(FRAME_BYTES)) begin
        frame_end = 1'b1;
      end
    end
  end

  assign psize      = size_q - FCW'(8);
  assign wr_pos     = (PIW + 1)'(idx_q) + (PIW + 1)'(cnt_q);
  assign fill       = (PIW + 1)'(idx_q) + (PIW + 1)'(psize);
  assign eo_new     = eo_q + EO_W'(psize);
  assign flush_need = (fill >= (PIW + 1)'(PAGE_BYTES)) ||
                      (24'(eo_q) + 24'(psize) >= 24'(total_q));
  assign copy_last  = (cnt_q == CW'(psize - FCW'(1)));
  assign row_last   = (cnt_q == CW'(ROWS - 1));
  assign refuse     = (len_q > 32'(limit_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_START) begin
          state_d = ST_BANNER;
        end else if (byte_acc && frame_end) begin
          state_d = ST_EVAL;
        end
      end
      ST_BANNER: if (emit_ok && cnt_q == CW'(4)) state_d = ST_IDLE;
      ST_EVAL: begin
        if (total_q == '0) begin
          state_d = refuse ? ST_REFUSE : ST_ERASE;
        end else if (sum_q != rxsum_q) begin
          state_d = ST_ACK;
        end else if (seq_q == 32'(eo_q)) begin
          state_d = ST_COPY_RD;
        end else begin
          state_d = ST_ACK;
        end
      end
      ST_REFUSE: if (emit_ok && cnt_q == CW'(4)) state_d = ST_IDLE;
      ST_ERASE:  if (emit_ok) state_d = ST_ACK;
      ST_ACK: begin
        if (emit_ok && cnt_q == CW'(4)) begin
          state_d = (ack_data_q && 24'(eo_q) >= 24'(total_q)) ? ST_DONE : ST_IDLE;
        end
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        if (copy_last) begin
          state_d = flush_need ? ST_FLUSH_RD : ST_ACK;
        end else begin
          state_d = ST_COPY_RD;
        end
      end
      ST_FLUSH_RD: state_d = ST_FLUSH_WR;
      ST_FLUSH_WR: begin
        if (emit_ok) begin
          state_d = row_last ? ST_ACK : ST_FLUSH_RD;
        end
      end
      ST_DONE: if (emit_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    kind = KIND_TX;
    tx   = '0;
    off  = '0;
    data = '0;
    last = 1'b0;
    unique case (state_q)
      ST_BANNER: begin
        emit = 1'b1;
        last = (cnt_q == CW'(4));
        unique case (cnt_q[2:0])
          3'd0:    tx = CH_STAR;
          3'd1:    tx = version_q[31:24];
          3'd2:    tx = version_q[23:16];
          3'd3:    tx = version_q[15:8];
          default: tx = version_q[7:0];
        endcase
      end
      ST_REFUSE: begin
        emit = 1'b1;
        last = (cnt_q == CW'(4));
        tx   = (cnt_q == CW'(4)) ? CH_STAR : CH_BANG;
      end
      ST_ERASE: begin
        emit = 1'b1;
        kind = KIND_ERASE;
      end
      ST_ACK: begin
        emit = 1'b1;
        last = (cnt_q == CW'(4)) && !(ack_data_q && 24'(eo_q) >= 24'(total_q));
        unique case (cnt_q[2:0])
          3'd0:    tx = CH_HASH;
          3'd1:    tx = eo_q[7:0];
          3'd2:    tx = eo_q[15:8];
          3'd3:    tx = {1'b0, eo_q[22:16]};
          default: tx = '0;
        endcase
      end
      ST_FLUSH_WR: begin
        emit = 1'b1;
        kind = KIND_WRITE;
        off  = base_q + OFF_W'({cnt_q, 3'b000});
        for (int b = 0; b < 8; b++) begin
          data[8*b +: 8] = vld_rd_q[b] ? page_rd_q[8*b +: 8] : ERASED;
        end
      end
      ST_DONE: begin
        emit = 1'b1;
        kind = KIND_DONE;
        last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      version_q   <= '0;
      fc_q        <= '0;
      total_q     <= '0;
      eo_q        <= '0;
      idx_q       <= '0;
      base_q      <= '0;
      finished_q  <= 1'b0;
      ack_data_q  <= 1'b0;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_LIMIT) begin
          limit_q <= cfg_data_i[LEN_W-1:0];
        end else begin
          version_q <= cfg_data_i;
        end
      end
      if (emit_ok) begin
        out_valid_q <= emit;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc && action_i == ACT_START) begin
            fc_q       <= '0;
            total_q    <= '0;
            eo_q       <= '0;
            idx_q      <= '0;
            base_q     <= '0;
            valid_q    <= '0;
            finished_q <= 1'b0;
          end else if (byte_acc) begin
            if (fc_q == FCW'(1) && (hdr0_q != HDR_FIRST || rx_byte_i != HDR_SECOND)) begin
              fc_q <= '0;
            end else if (frame_end) begin
              fc_q <= '0;
            end else begin
              fc_q <= fc_next;
            end
          end
        end
        ST_BANNER, ST_REFUSE, ST_ACK: if (emit_ok) cnt_q <= cnt_q + CW'(1);
        ST_EVAL: begin
          ack_data_q <= (total_q != '0);
          if (total_q == '0 && !refuse) begin
            total_q <= len_q[LEN_W-1:0];
            eo_q    <= '0;
            idx_q   <= '0;
            base_q  <= '0;
          end
        end
        ST_COPY_WR: begin
          if (wr_pos < (PIW + 1)'(PAGE_BYTES)) begin
            valid_q[wr_pos[PIW-1:0]] <= 1'b1;
          end
          if (copy_last) begin
            cnt_q <= '0;
            if (!flush_need) begin
              eo_q  <= eo_new;
              idx_q <= fill[PIW-1:0];
            end
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_FLUSH_WR: begin
          if (emit_ok) begin
            if (row_last) begin
              cnt_q   <= '0;
              valid_q <= '0;
              eo_q    <= eo_new;
              if (fill >= (PIW + 1)'(PAGE_BYTES)) begin
                idx_q  <= PIW'(fill - (PIW + 1)'(PAGE_BYTES));
                base_q <= base_q + OFF_W'(PAGE_BYTES);
              end else begin
                idx_q <= fill[PIW-1:0];
              end
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        ST_DONE: if (emit_ok) finished_q <= 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      kind_q <= kind;
      tx_q   <= tx;
      off_q  <= off;
      data_q <= data;
      last_q <= last;
    end
    if (byte_acc) begin
      frame_mem[fc_q[FAW-1:0]] <= rx_byte_i;
      if (frame_end) begin
        size_q <= fc_next;
      end
      if (fc_q == FCW'(0)) begin
        hdr0_q <= rx_byte_i;
      end
      if (fc_q >= FCW'(2) && fc_q <= FCW'(5)) begin
        len_q[8*(fc_q[1:0] ^ 2'd2) +: 8] <= rx_byte_i;
      end
      if (fc_q == FCW'(2)) begin
        rxsum_q[7:0] <= rx_byte_i;
      end
      if (fc_q == FCW'(3)) begin
        rxsum_q[15:8] <= rx_byte_i;
      end
      if (fc_q >= FCW'(4) && fc_q <= FCW'(7)) begin
        seq_q[8*fc_q[1:0] +: 8] <= rx_byte_i;
      end
      if (fc_q >= FCW'(4)) begin
        if (!fc_q[0]) begin
          lo_q <= rx_byte_i;
        end else if (fc_q == FCW'(5)) begin
          sum_q <= {rx_byte_i, lo_q};
        end else begin
          sum_q <= sum_q + {rx_byte_i, lo_q};
        end
      end
    end
    if (state_q == ST_COPY_RD) begin
      frame_rd_q <= frame_mem[FAW'(cnt_q) + FAW'(8)];
    end
    if (state_q == ST_COPY_WR && wr_pos < (PIW + 1)'(PAGE_BYTES)) begin
      page_mem[wr_pos[PIW-1:3]][8*wr_pos[2:0] +: 8] <= frame_rd_q;
    end
    if (state_q == ST_FLUSH_RD) begin
      page_rd_q <= page_mem[cnt_q[RW-1:0]];
      vld_rd_q  <= valid_q[{cnt_q[RW-1:0], 3'b000} +: 8];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign tx_byte_o      = tx_q;
  assign flash_offset_o = off_q;
  assign flash_data_o   = data_q;
  assign last_o         = last_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> state_q == ST_IDLE)
    else $error("Input transfer taken while the sequencer was busy.");

  a_flush_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH_RD |=> state_q == ST_FLUSH_WR)
    else $error("Page read was not followed by its flash word.");

  a_finished_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> total_q != '0 && 24'(eo_q) >= 24'(total_q))
    else $error("Session finished before the image was complete.");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q < FCW'(FRAME_BYTES))
    else $error("Frame count ran past the frame size.");

endmodule
